/* hw/rtl/fopc_pkg.sv */
`timescale 1ns / 1ps
package fopc_pkg;

    // sizes and number formats
    localparam int MAX_VARS       = 64;
    localparam int IDX_W          = 6;
    localparam int ADDR_W         = 2 * IDX_W;
    localparam int MEM_DEPTH      = MAX_VARS * MAX_VARS;
    localparam int CORR_W         = 16;
    localparam int CORR_FRAC_BITS = 15;
    localparam int METRIC_FRAC    = 28;
    localparam int SAMPLE_OFFSET  = 3;
    localparam int SIZE_W         = 7;
    localparam int SAMPLE_W       = 16;
    localparam int CFG_W          = 16;

    // operation codes
    localparam logic OP_WRITE   = 1'b0;
    localparam logic OP_COMPUTE = 1'b1;

    // result status codes
    localparam logic [1:0] ST_OK       = 2'd0;
    localparam logic [1:0] ST_BAD_PAIR = 2'd1;
    localparam logic [1:0] ST_NO_K     = 2'd2;

    // configuration register indexes
    localparam logic CFG_MATRIX_SIZE  = 1'b0;
    localparam logic CFG_SAMPLE_COUNT = 1'b1;

    // sequencer steps, also the command to the datapath
    localparam logic [4:0] S_IDLE  = 5'd0;
    localparam logic [4:0] S_CLR   = 5'd1;
    localparam logic [4:0] S_RDIJ  = 5'd2;
    localparam logic [4:0] S_PIJ   = 5'd3;
    localparam logic [4:0] S_KRD   = 5'd4;
    localparam logic [4:0] S_KCHK  = 5'd5;
    localparam logic [4:0] S_MA    = 5'd6;
    localparam logic [4:0] S_MB    = 5'd7;
    localparam logic [4:0] S_MC    = 5'd8;
    localparam logic [4:0] S_MD    = 5'd9;
    localparam logic [4:0] S_SQU_S = 5'd10;
    localparam logic [4:0] S_SQU_W = 5'd11;
    localparam logic [4:0] S_SQV_S = 5'd12;
    localparam logic [4:0] S_SQV_W = 5'd13;
    localparam logic [4:0] S_ME    = 5'd14;
    localparam logic [4:0] S_MF    = 5'd15;
    localparam logic [4:0] S_DVP_S = 5'd16;
    localparam logic [4:0] S_DVP_W = 5'd17;
    localparam logic [4:0] S_DVX_S = 5'd18;
    localparam logic [4:0] S_DVX_W = 5'd19;
    localparam logic [4:0] S_MG    = 5'd20;
    localparam logic [4:0] S_MH    = 5'd21;
    localparam logic [4:0] S_FIN   = 5'd22;
    localparam logic [4:0] S_SA    = 5'd23;
    localparam logic [4:0] S_SB    = 5'd24;
    localparam logic [4:0] S_SC    = 5'd25;
    localparam logic [4:0] S_SD_S  = 5'd26;
    localparam logic [4:0] S_SD_W  = 5'd27;
    localparam logic [4:0] S_SE_S  = 5'd28;
    localparam logic [4:0] S_SE_W  = 5'd29;
    localparam logic [4:0] S_OUT   = 5'd30;

    typedef struct packed {
        logic                     operation;
        logic [IDX_W-1:0]         row_index;
        logic [IDX_W-1:0]         col_index;
        logic signed [CORR_W-1:0] corr_value;
        logic                     edge_present;
    } t_in_item;

    typedef struct packed {
        logic [IDX_W-1:0]         pair_row;
        logic [IDX_W-1:0]         pair_col;
        logic [1:0]               status;
        logic signed [CORR_W-1:0] partial_corr;
        logic [31:0]              min_metric;
        logic [IDX_W-1:0]         best_k;
        logic [14:0]              spread;
        logic                     spread_valid;
    } t_out_item;

    typedef struct packed {
        logic clr_last;
        logic pair_bad;
        logic k_end;
        logic k_self;
        logic edges_ok;
        logic uv_bad;
        logic den_zero;
        logic sq_busy;
        logic dv_busy;
        logic found;
        logic samples_ok;
    } t_dp_status;

endpackage

/* hw/rtl/fopc_div.sv */
`timescale 1ns / 1ps
module fopc_div import fopc_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_start,
    input  logic [59:0] i_num,
    input  logic [30:0] i_den,
    input  logic [4:0]  i_cap_bit,
    output logic        o_busy,
    output logic [31:0] o_quot
);

    logic        r_busy;
    logic        r_first;
    logic [4:0]  r_bit;
    logic [61:0] r_rem;
    logic [61:0] r_dsh;
    logic [31:0] r_q;
    logic        w_ge;

    assign w_ge = (r_rem >= r_dsh);

    // restoring division one quotient bit a cycle, capped at 2^cap_bit
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
        end else if (i_start) begin
            r_busy <= 1'b1;
        end else if (r_busy) begin
            if ((r_first && w_ge) || (r_bit == 5'd0)) begin
                r_busy <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_rem   <= {2'b0, i_num};
            r_dsh   <= {31'b0, i_den} << i_cap_bit;
            r_bit   <= i_cap_bit;
            r_first <= 1'b1;
            r_q     <= '0;
        end else if (r_busy) begin
            r_first <= 1'b0;
            if (r_first && w_ge) begin
                r_q <= 32'd1 << r_bit;
            end else begin
                if (w_ge) begin
                    r_rem      <= r_rem - r_dsh;
                    r_q[r_bit] <= 1'b1;
                end
                r_dsh <= r_dsh >> 1;
                if (r_bit != 5'd0) begin
                    r_bit <= r_bit - 5'd1;
                end
            end
        end
    end

    assign o_busy = r_busy;
    assign o_quot = r_q;

endmodule

/* hw/rtl/fopc_sqrt.sv */
`timescale 1ns / 1ps
module fopc_sqrt import fopc_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_start,
    input  logic [31:0] i_x,
    output logic        o_busy,
    output logic [15:0] o_root
);

    logic        r_busy;
    logic [3:0]  r_cnt;
    logic [31:0] r_x;
    logic [31:0] r_r;
    logic [31:0] r_bit;
    logic [31:0] w_trial;

    assign w_trial = r_r + r_bit;

    // digit-by-digit floor root, two radicand bits a cycle
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
        end else if (i_start) begin
            r_busy <= 1'b1;
        end else if (r_busy && (r_cnt == 4'd0)) begin
            r_busy <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_x   <= i_x;
            r_r   <= '0;
            r_bit <= 32'd1 << 30;
            r_cnt <= 4'd15;
        end else if (r_busy) begin
            if (r_x >= w_trial) begin
                r_x <= r_x - w_trial;
                r_r <= (r_r >> 1) + r_bit;
            end else begin
                r_r <= r_r >> 1;
            end
            r_bit <= r_bit >> 2;
            r_cnt <= r_cnt - 4'd1;
        end
    end

    assign o_busy = r_busy;
    assign o_root = r_r[15:0];

endmodule

/* hw/rtl/fopc_dp.sv */
`timescale 1ns / 1ps
module fopc_dp import fopc_pkg::*; (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic [4:0]       i_cmd,
    input  logic             i_accept,
    input  t_in_item         i_in,
    input  logic             i_cfg_we,
    input  logic             i_cfg_idx,
    input  logic [CFG_W-1:0] i_cfg_wdata,
    output t_dp_status       o_stat,
    output t_out_item        o_res
);

    localparam logic [30:0] ONE2 = 31'd1 << (2 * CORR_FRAC_BITS);

    // configuration
    logic [SIZE_W-1:0]   r_matrix_size;
    logic [SAMPLE_W-1:0] r_sample_count;
    logic [SIZE_W-1:0]   w_n;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_matrix_size  <= SIZE_W'(MAX_VARS);
            r_sample_count <= '0;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                CFG_MATRIX_SIZE:  r_matrix_size  <= i_cfg_wdata[SIZE_W-1:0];
                CFG_SAMPLE_COUNT: r_sample_count <= i_cfg_wdata[SAMPLE_W-1:0];
                default: ;
            endcase
        end
    end

    assign w_n = (r_matrix_size > SIZE_W'(MAX_VARS)) ? SIZE_W'(MAX_VARS) : r_matrix_size;

    // pair registers
    logic [IDX_W-1:0]  r_i;
    logic [IDX_W-1:0]  r_j;
    logic [SIZE_W-1:0] r_k;

    always_ff @(posedge i_clk) begin
        if (i_accept && (i_in.operation == OP_COMPUTE)) begin
            r_i <= i_in.row_index;
            r_j <= i_in.col_index;
        end
    end

    // matrix store: edge flag over correlation, cleared by a sweep after reset
    logic [CORR_W:0]   mem [0:MEM_DEPTH-1];
    logic [CORR_W:0]   r_rda;
    logic [CORR_W:0]   r_rdb;
    logic [ADDR_W-1:0] r_clr_addr;
    logic              w_we;
    logic [ADDR_W-1:0] w_waddr;
    logic [CORR_W:0]   w_wdata;
    logic [ADDR_W-1:0] w_addr_a;
    logic [ADDR_W-1:0] w_addr_b;

    assign w_we     = (i_cmd == S_CLR) || (i_accept && (i_in.operation == OP_WRITE));
    assign w_waddr  = (i_cmd == S_CLR) ? r_clr_addr : {i_in.row_index, i_in.col_index};
    assign w_wdata  = (i_cmd == S_CLR) ? '0 : {i_in.edge_present, i_in.corr_value};
    assign w_addr_a = (i_cmd == S_RDIJ) ? {r_i, r_j} : {r_i, r_k[IDX_W-1:0]};
    assign w_addr_b = {r_j, r_k[IDX_W-1:0]};

    always_ff @(posedge i_clk) begin
        if (w_we) begin
            mem[w_waddr] <= w_wdata;
        end
        r_rda <= mem[w_addr_a];
        r_rdb <= mem[w_addr_b];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clr_addr <= '0;
        end else if (i_cmd == S_CLR) begin
            r_clr_addr <= r_clr_addr + ADDR_W'(1);
        end
    end

    // shared multiplier with registered product
    logic signed [CORR_W-1:0] r_rij;
    logic signed [CORR_W-1:0] r_a;
    logic signed [CORR_W-1:0] r_b;
    logic [15:0]              r_ru;
    logic [15:0]              r_rv;
    logic [30:0]              r_x;
    logic signed [CORR_W-1:0] r_pc;
    logic [15:0]              r_t;
    logic signed [31:0]       w_ma;
    logic signed [31:0]       w_mb;
    logic signed [63:0]       r_prod;

    always_comb begin
        case (i_cmd)
            S_MA:    begin w_ma = 32'(r_a);  w_mb = 32'(r_a);  end
            S_MB:    begin w_ma = 32'(r_b);  w_mb = 32'(r_b);  end
            S_MC:    begin w_ma = 32'(r_a);  w_mb = 32'(r_b);  end
            S_ME:    begin w_ma = $signed({16'b0, r_ru}); w_mb = $signed({16'b0, r_rv}); end
            S_MG:    begin w_ma = $signed({1'b0, r_x});   w_mb = $signed({1'b0, r_x});   end
            S_SA:    begin w_ma = 32'(r_pc); w_mb = 32'(r_pc); end
            S_SC:    begin w_ma = $signed({16'b0, r_t});  w_mb = $signed({16'b0, r_t});  end
            default: begin w_ma = '0;        w_mb = '0;        end
        endcase
    end

    always_ff @(posedge i_clk) begin
        r_prod <= w_ma * w_mb;
    end

    // numerator terms
    logic [30:0]        r_u;
    logic [30:0]        r_v;
    logic               r_num_neg;
    logic [31:0]        r_num_mag;
    logic [30:0]        r_nabs_mag;
    logic [30:0]        r_den;
    logic signed [16:0] w_rij_ext;
    logic [16:0]        w_rij_mag;
    logic signed [32:0] w_num;
    logic signed [32:0] w_ab;
    logic signed [32:0] w_ab_mag;
    logic signed [32:0] w_nabs;
    logic signed [32:0] w_num_abs;
    logic signed [32:0] w_nabs_abs;

    assign w_rij_ext  = {r_rij[CORR_W-1], r_rij};
    assign w_rij_mag  = (w_rij_ext < 0) ? 17'(-w_rij_ext) : 17'(w_rij_ext);
    assign w_ab       = r_prod[32:0];
    assign w_ab_mag   = (w_ab < 0) ? -w_ab : w_ab;
    assign w_num      = $signed({{2{r_rij[CORR_W-1]}}, r_rij, 15'b0}) - w_ab;
    assign w_nabs     = $signed({1'b0, w_rij_mag, 15'b0}) - $signed({2'b0, w_ab_mag[30:0]});
    assign w_num_abs  = (w_num < 0) ? -w_num : w_num;
    assign w_nabs_abs = (w_nabs < 0) ? -w_nabs : w_nabs;

    always_ff @(posedge i_clk) begin
        case (i_cmd)
            S_PIJ:  r_rij <= r_rda[CORR_W-1:0];
            S_KCHK: begin
                r_a <= r_rda[CORR_W-1:0];
                r_b <= r_rdb[CORR_W-1:0];
            end
            S_MB:   r_u <= ONE2 - r_prod[30:0];
            S_MC:   r_v <= ONE2 - r_prod[30:0];
            S_MD:   begin
                r_num_neg  <= w_num < 0;
                r_num_mag  <= w_num_abs[31:0];
                r_nabs_mag <= w_nabs_abs[30:0];
            end
            S_MF:   r_den <= r_prod[30:0];
            default: ;
        endcase
    end

    // shared root unit
    logic        w_sq_start;
    logic [31:0] w_sq_x;
    logic        w_sq_busy;
    logic [15:0] w_sq_root;
    logic        w_dv_start;
    logic [59:0] w_dv_num;
    logic [30:0] w_dv_den;
    logic [4:0]  w_dv_cap;
    logic        w_dv_busy;
    logic [31:0] w_dv_q;

    assign w_sq_start = (i_cmd == S_SQU_S) || (i_cmd == S_SQV_S) || (i_cmd == S_SE_S);

    always_comb begin
        case (i_cmd)
            S_SQU_S: w_sq_x = {1'b0, r_u};
            S_SQV_S: w_sq_x = {1'b0, r_v};
            default: w_sq_x = w_dv_q;
        endcase
    end

    fopc_sqrt u_sqrt (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (w_sq_start),
        .i_x     (w_sq_x),
        .o_busy  (w_sq_busy),
        .o_root  (w_sq_root)
    );

    // shared divider
    assign w_dv_start = (i_cmd == S_DVP_S) || (i_cmd == S_DVX_S) || (i_cmd == S_SD_S);

    always_comb begin
        case (i_cmd)
            S_DVP_S: begin
                w_dv_num = {13'b0, r_num_mag, 15'b0};
                w_dv_den = r_den;
                w_dv_cap = 5'(CORR_FRAC_BITS);
            end
            S_DVX_S: begin
                w_dv_num = {1'b0, r_nabs_mag, 28'b0};
                w_dv_den = r_den;
                w_dv_cap = 5'd30;
            end
            default: begin
                w_dv_num = r_prod[59:0];
                w_dv_den = {15'b0, r_sample_count - SAMPLE_W'(SAMPLE_OFFSET)};
                w_dv_cap = 5'd31;
            end
        endcase
    end

    fopc_div u_div (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_start   (w_dv_start),
        .i_num     (w_dv_num),
        .i_den     (w_dv_den),
        .i_cap_bit (w_dv_cap),
        .o_busy    (w_dv_busy),
        .o_quot    (w_dv_q)
    );

    // unit results
    always_ff @(posedge i_clk) begin
        if ((i_cmd == S_SQU_W) && !w_sq_busy) r_ru <= w_sq_root;
        if ((i_cmd == S_SQV_W) && !w_sq_busy) r_rv <= w_sq_root;
        if ((i_cmd == S_DVP_W) && !w_dv_busy) begin
            if (r_num_neg) begin
                r_pc <= -$signed(w_dv_q[15:0]);
            end else if (w_dv_q > 32'd32767) begin
                r_pc <= 16'sh7FFF;
            end else begin
                r_pc <= $signed(w_dv_q[15:0]);
            end
        end
        // pc^2 for spread reuses best partial correlation
        if (i_cmd == S_FIN) begin
            r_pc <= r_best_pc;
        end
        if ((i_cmd == S_DVX_W) && !w_dv_busy) r_x <= w_dv_q[30:0];
        if (i_cmd == S_SB) begin
            r_t <= 16'((ONE2 - r_prod[30:0]) >> CORR_FRAC_BITS);
        end
    end

    // status flags
    logic w_k_self;
    logic w_k_end;
    logic w_edges_ok;
    logic w_uv_bad;
    logic w_den_zero;
    logic w_pair_bad;

    assign w_k_end    = r_k >= w_n;
    assign w_k_self   = (r_k[IDX_W-1:0] == r_i) || (r_k[IDX_W-1:0] == r_j);
    assign w_edges_ok = r_rda[CORR_W] && r_rdb[CORR_W];
    assign w_uv_bad   = (r_u == '0) || (r_v == '0);
    assign w_den_zero = (r_prod == '0);
    assign w_pair_bad = !(r_i < r_j) || ({1'b0, r_j} >= w_n) || !r_rda[CORR_W];

    // scan position and running minimum
    logic                     r_found;
    logic [31:0]              r_best_metric;
    logic signed [CORR_W-1:0] r_best_pc;
    logic [IDX_W-1:0]         r_best_k;
    logic [1:0]               r_status;
    logic [14:0]              r_spread;
    logic                     r_spread_valid;
    logic [31:0]              w_metric;
    logic                     w_k_next;

    assign w_metric = (r_prod[63:60] != 4'd0) ? 32'hFFFF_FFFF : r_prod[59:28];
    assign w_k_next = ((i_cmd == S_KRD) && !w_k_end && w_k_self) ||
                      ((i_cmd == S_KCHK) && !w_edges_ok) ||
                      ((i_cmd == S_MD) && w_uv_bad) ||
                      ((i_cmd == S_MF) && w_den_zero) ||
                      (i_cmd == S_MH);

    always_ff @(posedge i_clk) begin
        if (i_cmd == S_PIJ) begin
            r_k <= '0;
        end else if (w_k_next) begin
            r_k <= r_k + SIZE_W'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_found <= 1'b0;
        end else if (i_cmd == S_PIJ) begin
            r_found <= 1'b0;
        end else if ((i_cmd == S_MH) && (!r_found || (w_metric < r_best_metric))) begin
            r_found <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if ((i_cmd == S_MH) && (!r_found || (w_metric < r_best_metric))) begin
            r_best_metric <= w_metric;
            r_best_pc     <= r_pc;
            r_best_k      <= r_k[IDX_W-1:0];
        end
        case (i_cmd)
            S_PIJ:  r_status <= ST_BAD_PAIR;
            S_FIN:  begin
                r_status       <= r_found ? ST_OK : ST_NO_K;
                r_spread       <= '0;
                r_spread_valid <= 1'b0;
            end
            S_SE_W: begin
                if (!w_sq_busy) begin
                    r_spread       <= w_sq_root[15] ? 15'h7FFF : w_sq_root[14:0];
                    r_spread_valid <= 1'b1;
                end
            end
            default: ;
        endcase
    end

    assign o_stat.clr_last   = (r_clr_addr == '1);
    assign o_stat.pair_bad   = w_pair_bad;
    assign o_stat.k_end      = w_k_end;
    assign o_stat.k_self     = w_k_self;
    assign o_stat.edges_ok   = w_edges_ok;
    assign o_stat.uv_bad     = w_uv_bad;
    assign o_stat.den_zero   = w_den_zero;
    assign o_stat.sq_busy    = w_sq_busy;
    assign o_stat.dv_busy    = w_dv_busy;
    assign o_stat.found      = r_found;
    assign o_stat.samples_ok = r_sample_count > SAMPLE_W'(SAMPLE_OFFSET);

    // result fields: payload zero unless ok, pair and status always shown
    logic w_ok;
    assign w_ok = (r_status == ST_OK);

    assign o_res.pair_row     = r_i;
    assign o_res.pair_col     = r_j;
    assign o_res.status       = r_status;
    assign o_res.partial_corr = w_ok ? r_best_pc : '0;
    assign o_res.min_metric   = w_ok ? r_best_metric : '0;
    assign o_res.best_k       = w_ok ? r_best_k : '0;
    assign o_res.spread       = w_ok ? r_spread : '0;
    assign o_res.spread_valid = w_ok && r_spread_valid;

endmodule

/* hw/rtl/fopc_ctrl.sv */
`timescale 1ns / 1ps
module fopc_ctrl import fopc_pkg::*; (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_start,
    input  logic       i_op,
    input  t_dp_status i_stat,
    output logic [4:0] o_cmd,
    output logic       o_busy,
    output logic       o_done
);

    logic [4:0] r_state;
    logic [4:0] n_state;

    // step sequencing
    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE:  if (i_start && (i_op == OP_COMPUTE)) n_state = S_RDIJ;
            S_CLR:   if (i_stat.clr_last) n_state = S_IDLE;
            S_RDIJ:  n_state = S_PIJ;
            S_PIJ:   n_state = i_stat.pair_bad ? S_OUT : S_KRD;
            S_KRD: begin
                if (i_stat.k_end) begin
                    n_state = S_FIN;
                end else if (!i_stat.k_self) begin
                    n_state = S_KCHK;
                end
            end
            S_KCHK:  n_state = i_stat.edges_ok ? S_MA : S_KRD;
            S_MA:    n_state = S_MB;
            S_MB:    n_state = S_MC;
            S_MC:    n_state = S_MD;
            S_MD:    n_state = i_stat.uv_bad ? S_KRD : S_SQU_S;
            S_SQU_S: n_state = S_SQU_W;
            S_SQU_W: if (!i_stat.sq_busy) n_state = S_SQV_S;
            S_SQV_S: n_state = S_SQV_W;
            S_SQV_W: if (!i_stat.sq_busy) n_state = S_ME;
            S_ME:    n_state = S_MF;
            S_MF:    n_state = i_stat.den_zero ? S_KRD : S_DVP_S;
            S_DVP_S: n_state = S_DVP_W;
            S_DVP_W: if (!i_stat.dv_busy) n_state = S_DVX_S;
            S_DVX_S: n_state = S_DVX_W;
            S_DVX_W: if (!i_stat.dv_busy) n_state = S_MG;
            S_MG:    n_state = S_MH;
            S_MH:    n_state = S_KRD;
            S_FIN:   n_state = (i_stat.found && i_stat.samples_ok) ? S_SA : S_OUT;
            S_SA:    n_state = S_SB;
            S_SB:    n_state = S_SC;
            S_SC:    n_state = S_SD_S;
            S_SD_S:  n_state = S_SD_W;
            S_SD_W:  if (!i_stat.dv_busy) n_state = S_SE_S;
            S_SE_S:  n_state = S_SE_W;
            S_SE_W:  if (!i_stat.sq_busy) n_state = S_OUT;
            S_OUT:   n_state = S_IDLE;
            default: n_state = S_IDLE;
        endcase
    end

    // state register, clearing sweep after reset
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_CLR;
        end else begin
            r_state <= n_state;
        end
    end

    assign o_cmd  = r_state;
    assign o_busy = (r_state != S_IDLE);
    assign o_done = (r_state == S_OUT);

endmodule

/* hw/rtl/first_order_partial_corr_min_top.sv */
`timescale 1ns / 1ps
// first-order partial correlation, minimum over conditioning variables
//
// input channel: an item is taken at a rising edge with i_start high and
// o_busy low. a write item stores one matrix entry and its edge flag in that
// same cycle and leaves the block idle, so writes go one per cycle.
// a compute item names a pair (i, j) and yields exactly one result on o_res,
// shown for one cycle with o_done high; the receiver cannot hold it off.
// configuration: i_cfg_we with i_cfg_idx 0 (matrix size) or 1 (sample count),
// written while the block is idle; the block itself does not enforce this.
// the work for each usable k is set by the single iterative square root unit
// (used twice per k) and the single restoring divider (one quotient bit a
// cycle, used twice per k); the spread uses both units once more.
// o_busy stays high from acceptance until the result cycle, so items are
// worked one at a time.
// after reset the matrix store is swept clear, all 4096 entries, with o_busy high;
// configuration writes are taken during the sweep.
module first_order_partial_corr_min_top import fopc_pkg::*; (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_start,
    input  t_in_item         i_in,
    output logic             o_busy,
    output logic             o_done,
    output t_out_item        o_res,
    input  logic             i_cfg_we,
    input  logic             i_cfg_idx,
    input  logic [CFG_W-1:0] i_cfg_wdata
);

    logic [4:0] w_cmd;
    t_dp_status w_stat;
    logic       w_busy;
    logic       w_accept;

    // input transaction
    assign w_accept = i_start && !w_busy;

    fopc_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (i_start),
        .i_op    (i_in.operation),
        .i_stat  (w_stat),
        .o_cmd   (w_cmd),
        .o_busy  (w_busy),
        .o_done  (o_done)
    );

    fopc_dp u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (w_cmd),
        .i_accept    (w_accept),
        .i_in        (i_in),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_idx   (i_cfg_idx),
        .i_cfg_wdata (i_cfg_wdata),
        .o_stat      (w_stat),
        .o_res       (o_res)
    );

    assign o_busy = w_busy;

endmodule

/* hw/rtl/fopc_chk.sv */
`timescale 1ns / 1ps
module fopc_chk import fopc_pkg::*; (
    input logic      i_clk,
    input logic      i_rst_n,
    input logic      i_start,
    input t_in_item  i_in,
    input logic      o_busy,
    input logic      o_done,
    input t_out_item o_res
);

    // a result strobe lasts one cycle
    a_done_pulse: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |=> !o_done)
        else $error("result strobe longer than one cycle");

    // a compute transaction keeps the block busy in the next cycle
    a_busy_after_start: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_start && !o_busy && (i_in.operation == OP_COMPUTE)) |=> o_busy)
        else $error("compute transaction did not start work");

    // failed pairs carry zero payload
    a_fail_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_done && (o_res.status != ST_OK)) |->
        ((o_res.min_metric == '0) && (o_res.best_k == '0) &&
         (o_res.partial_corr == '0) && !o_res.spread_valid))
        else $error("non-ok result with nonzero payload");

    // chosen conditioning variable is neither member of the pair
    a_k_distinct: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_done && (o_res.status == ST_OK)) |->
        ((o_res.best_k != o_res.pair_row) && (o_res.best_k != o_res.pair_col)))
        else $error("best k equals a pair member");

endmodule

bind first_order_partial_corr_min_top fopc_chk u_fopc_chk (
    .i_clk   (i_clk),
    .i_rst_n (i_rst_n),
    .i_start (i_start),
    .i_in    (i_in),
    .o_busy  (o_busy),
    .o_done  (o_done),
    .o_res   (o_res)
);
